// File: hdl/sia_pkg.sv
// Package for the slot index allocator: request codes, controller states
// and the command and status structs between controller and datapath.
// No dependencies.
package sia_pkg;

  localparam int MAX_SLOTS_DEF = 256;
  localparam int STACK_LIMIT   = 256;
  localparam int KIND_W        = 2;
  localparam int INDEX_W       = 8;
  localparam int CAP_W         = 9;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic pop_issue;
    logic pop_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pop_needed;
  } dp_status_t;

endpackage

// File: hdl/sia_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/sia_ctrl.sv
// Controller state machine of the slot index allocator.
// Depends on sia_pkg for the state type and the command and status structs.
module sia_ctrl
  import sia_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t status,
  output logic       busy,
  output ctrl_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.pop_needed) begin
          state_nxt = ST_POP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy          = 1'b1;
    cmd.latch     = 1'b0;
    cmd.exec      = 1'b0;
    cmd.pop_issue = 1'b0;
    cmd.pop_done  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      ST_EXEC: begin
        cmd.exec      = !status.pop_needed;
        cmd.pop_issue = status.pop_needed;
      end
      ST_POP: begin
        cmd.pop_done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_pop_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> $past(state_r == ST_EXEC))
    else $error("pop state entered without a preceding execute state");

  a_exec_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> $past(start && (state_r == ST_IDLE)))
    else $error("execute state entered without an accepted request");

endmodule

// File: hdl/sia_dpath.sv
// Datapath of the slot index allocator: high-water mark, freed-index stack
// with its depth counter, capacity register and result registers.
// Depends on sia_pkg and instantiates sia_ram for the stack.
module sia_dpath
  import sia_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         status,
  input  logic               cfg_we,
  input  logic [CAP_W-1:0]   cfg_wdata,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [INDEX_W-1:0] in_slot_index,
  output logic               out_valid,
  output logic [INDEX_W-1:0] out_granted_index,
  output logic               out_ok,
  output logic [INDEX_W-1:0] out_high_water
);

  localparam int POOL = (MAX_SLOTS < STACK_LIMIT) ? MAX_SLOTS : STACK_LIMIT;
  localparam int AW   = $clog2(POOL);
  localparam int DW   = $clog2(POOL + 1);

  logic [CAP_W-1:0]   cap_r;
  logic [KIND_W-1:0]  kind_r;
  logic [INDEX_W-1:0] idx_r;
  logic [INDEX_W-1:0] mark_r;
  logic [INDEX_W-1:0] mark_nxt;
  logic [DW-1:0]      depth_r;
  logic [DW-1:0]      depth_nxt;
  logic               valid_r;
  logic               valid_nxt;
  logic [INDEX_W-1:0] granted_r;
  logic [INDEX_W-1:0] granted_nxt;
  logic               ok_r;
  logic               ok_nxt;

  logic [CAP_W-1:0]   cap_eff;
  logic [DW-1:0]      depth_dec;
  logic               ram_we;
  logic [INDEX_W-1:0] ram_rdata;

  assign cap_eff   = (cap_r < CAP_W'(POOL)) ? cap_r : CAP_W'(POOL);
  assign depth_dec = depth_r - DW'(1);

  assign status.pop_needed = (kind_r == KIND_ALLOC) && (depth_r != '0);

  always_comb begin
    mark_nxt    = mark_r;
    depth_nxt   = depth_r;
    valid_nxt   = cmd.exec || cmd.pop_done;
    granted_nxt = '0;
    ok_nxt      = 1'b0;
    ram_we      = 1'b0;
    if (cmd.pop_issue) begin
      depth_nxt = depth_dec;
    end
    if (cmd.pop_done) begin
      granted_nxt = ram_rdata;
      ok_nxt      = 1'b1;
    end
    if (cmd.exec) begin
      case (kind_r)
        KIND_ALLOC: begin
          if (({1'b0, mark_r} + CAP_W'(1)) < cap_eff) begin
            granted_nxt = mark_r;
            mark_nxt    = mark_r + INDEX_W'(1);
            ok_nxt      = 1'b1;
          end
        end
        KIND_FREE: begin
          if ((mark_r != '0) && (idx_r == (mark_r - INDEX_W'(1)))) begin
            mark_nxt = mark_r - INDEX_W'(1);
            ok_nxt   = 1'b1;
          end else if (depth_r < DW'(POOL)) begin
            ram_we    = 1'b1;
            depth_nxt = depth_r + DW'(1);
            ok_nxt    = 1'b1;
          end
        end
        KIND_CLEAR: begin
          mark_nxt  = '0;
          depth_nxt = '0;
          ok_nxt    = 1'b1;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  sia_ram #(
    .WIDTH (INDEX_W),
    .DEPTH (POOL)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (depth_r[AW-1:0]),
    .wdata (idx_r),
    .re    (cmd.pop_issue),
    .raddr (depth_dec[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= '0;
      mark_r  <= '0;
      depth_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      mark_r  <= mark_nxt;
      depth_r <= depth_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_kind;
      idx_r  <= in_slot_index;
    end
    if (valid_nxt) begin
      granted_r <= granted_nxt;
      ok_r      <= ok_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_granted_index = granted_r;
  assign out_ok            = ok_r;
  assign out_high_water    = mark_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(POOL))
    else $error("freed stack depth exceeds the pool size");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> $past(cmd.exec || cmd.pop_done))
    else $error("result strobe without a completed request");

endmodule

// File: hdl/slot_index_allocator.sv
// Slot index allocator top level. A request is taken when start is high and busy
// is low; its result is strobed on out_valid for one cycle, registered from the
// execute state, or from the pop state when an allocate pops the freed stack
// (registered RAM read). Busy holds off a new request until the last one is done.
// The synchronous reset clears the mark, the stack depth and the capacity; the
// stack RAM needs no clearing. Results cannot be held off by the receiver.
module slot_index_allocator
  import sia_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [INDEX_W-1:0] in_slot_index,
  output logic               out_valid,
  output logic [INDEX_W-1:0] out_granted_index,
  output logic               out_ok,
  output logic [INDEX_W-1:0] out_high_water,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CAP_W-1:0]   cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  sia_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  sia_dpath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_wdata         (cfg_wdata),
    .in_kind           (in_kind),
    .in_slot_index     (in_slot_index),
    .out_valid         (out_valid),
    .out_granted_index (out_granted_index),
    .out_ok            (out_ok),
    .out_high_water    (out_high_water)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for slot_index_allocator: directed and random requests,
// each checked against a behavioral model of the allocator kept in this file.
// Depends on sia_pkg and the slot_index_allocator RTL.
module testbench;
  import sia_pkg::*;

  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
  localparam int POOL_SLOTS = (MAX_SLOTS_DEF < STACK_LIMIT) ? MAX_SLOTS_DEF : STACK_LIMIT;
  localparam int IDLE_LIMIT = 400;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] index;
  } slot_request_t;

  typedef struct packed {
    logic [INDEX_W-1:0] granted;
    logic               ok;
    logic [INDEX_W-1:0] high_water;
  } slot_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [KIND_W-1:0]  in_kind = KIND_ALLOC;
  logic [INDEX_W-1:0] in_slot_index = '0;
  logic               out_valid;
  logic [INDEX_W-1:0] out_granted_index;
  logic               out_ok;
  logic [INDEX_W-1:0] out_high_water;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CAP_W-1:0]   cfg_wdata = '0;

  slot_request_t pending_requests[$];
  slot_result_t  expected_results[$];

  logic [CAP_W-1:0]   capacity = '0;
  logic [INDEX_W-1:0] mark = '0;
  logic [CAP_W-1:0]   stack_depth = '0;
  logic [INDEX_W-1:0] freed_slots [STACK_LIMIT];

  logic req_taken = 1'b0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   idle_cycles = 0;
  int   n_requests = 0;
  int   n_results = 0;
  int   n_cfg_writes = 0;
  int   n_alloc_fail = 0;
  int   n_dropped = 0;
  int   n_pops = 0;
  int   n_errors = 0;

  slot_index_allocator uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_slot_index     (in_slot_index),
    .out_valid         (out_valid),
    .out_granted_index (out_granted_index),
    .out_ok            (out_ok),
    .out_high_water    (out_high_water),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_error(input string what);
    n_errors++;
    if (n_errors <= 30) $display("ERROR at %0t: %s", $time, what);
  endtask

  function automatic slot_result_t apply_slot_request(slot_request_t req);
    slot_result_t res;
    int cap_eff;
    res = '0;
    cap_eff = (int'(capacity) < POOL_SLOTS) ? int'(capacity) : POOL_SLOTS;
    case (req.kind)
      KIND_ALLOC: begin
        if (stack_depth > 0) begin
          stack_depth = stack_depth - 1'b1;
          res.granted = freed_slots[stack_depth[INDEX_W-1:0]];
          res.ok = 1'b1;
          n_pops++;
        end else if (int'(mark) + 1 < cap_eff) begin
          res.granted = mark;
          mark = mark + 1'b1;
          res.ok = 1'b1;
        end else begin
          n_alloc_fail++;
        end
      end
      KIND_FREE: begin
        if (mark != 0 && req.index == mark - 8'd1) begin
          mark = mark - 1'b1;
          res.ok = 1'b1;
        end else if (stack_depth < POOL_SLOTS) begin
          freed_slots[stack_depth[INDEX_W-1:0]] = req.index;
          stack_depth = stack_depth + 1'b1;
          res.ok = 1'b1;
        end else begin
          n_dropped++;
        end
      end
      KIND_CLEAR: begin
        mark = '0;
        stack_depth = '0;
        res.ok = 1'b1;
      end
      default: begin
      end
    endcase
    res.high_water = mark;
    return res;
  endfunction

  always @(posedge clk) begin
    slot_result_t want;
    slot_request_t req;
    if (!rst_n) begin
      mark = '0;
      stack_depth = '0;
      capacity = '0;
      req_taken <= 1'b0;
    end else begin
      if (out_valid) begin
        n_results++;
        if (expected_results.size() == 0) begin
          report_error($sformatf("result with no request outstanding (granted_index %0d)",
                                 out_granted_index));
        end else begin
          want = expected_results.pop_front();
          if (out_granted_index !== want.granted)
            report_error($sformatf("granted_index is %0d, predicted %0d",
                                   out_granted_index, want.granted));
          if (out_ok !== want.ok)
            report_error($sformatf("ok is %0b, predicted %0b", out_ok, want.ok));
          if (out_high_water !== want.high_water)
            report_error($sformatf("high_water is %0d, predicted %0d",
                                   out_high_water, want.high_water));
        end
      end
      if (start && !busy) begin
        req.kind = in_kind;
        req.index = in_slot_index;
        expected_results.insert(expected_results.size(), apply_slot_request(req));
        n_requests++;
      end
      if (cfg_valid && cfg_ready) begin
        capacity = cfg_wdata;
        n_cfg_writes++;
      end
      req_taken <= start && !busy;
    end
  end

  always @(negedge clk) begin
    slot_request_t req;
    if (rst_n && (!start || req_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        req = pending_requests.pop_front();
        start <= 1'b1;
        in_kind <= req.kind;
        in_slot_index <= req.index;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 2);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no activity for %0d cycles.", IDLE_LIMIT);
      $display("slot_index_allocator: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_request(input logic [KIND_W-1:0] kind, input int index);
    slot_request_t req;
    req.kind = kind;
    req.index = index[INDEX_W-1:0];
    pending_requests.insert(pending_requests.size(), req);
  endtask

  task automatic add_mixed(input int count, input int span);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) push_request(KIND_ALLOC, $urandom_range(0, 255));
      else if (r < 72) push_request(KIND_FREE, $urandom_range(0, span));
      else if (r < 94) push_request(KIND_FREE, $urandom_range(0, 255));
      else if (r < 97) push_request(KIND_CLEAR, $urandom_range(0, 255));
      else push_request(KIND_RESERVED, $urandom_range(0, 255));
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || start || expected_results.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_capacity(input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_wdata <= value[CAP_W-1:0];
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int cap;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_capacity(0);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_FREE, 5);
    push_request(KIND_ALLOC, 255);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_RESERVED, 255);
    push_request(KIND_FREE, 0);
    push_request(KIND_FREE, 255);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_CLEAR, 170);
    push_request(KIND_ALLOC, 0);
    wait_drained();

    write_capacity(1);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_FREE, 7);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_ALLOC, 0);
    wait_drained();

    write_capacity(4);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_FREE, 2);
    push_request(KIND_FREE, 0);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_ALLOC, 0);
    wait_drained();

    write_capacity(2);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_FREE, 2);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_FREE, 1);
    push_request(KIND_ALLOC, 0);
    wait_drained();

    for (int p = 0; p < 2; p++) begin
      cap = $urandom_range(2, 12);
      write_capacity(cap);
      push_request(KIND_CLEAR, 0);
      add_mixed(40, cap);
      wait_drained();
    end

    write_capacity(511);
    push_request(KIND_CLEAR, 0);
    for (int i = 0; i < 258; i++) push_request(KIND_FREE, $urandom_range(0, 255));
    add_mixed(80, 255);
    wait_drained();

    repeat (8) @(posedge clk);
    $display("Ran %0d requests under %0d capacity settings and compared %0d results.",
             n_requests, n_cfg_writes, n_results);
    $display("Failed allocates %0d, dropped frees %0d, stack pops %0d, errors %0d.",
             n_alloc_fail, n_dropped, n_pops, n_errors);
    if (n_errors == 0) begin
      $display("slot_index_allocator: match");
    end else begin
      $display("slot_index_allocator: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/sia_pkg.sv
hdl/sia_ram.sv
hdl/sia_ctrl.sv
hdl/sia_dpath.sv
hdl/slot_index_allocator.sv
tb/testbench.sv
